[src/sle_pkg.sv]
// Shared codes, defaults and result type of the sequential list engine.
package sle_pkg;

  // Default sizing
  localparam int CAPACITY_DEF   = 128;
  localparam int DATA_WIDTH_DEF = 32;

  // Request kinds
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_GET    = 3'd2;
  localparam logic [2:0] KIND_LOCATE = 3'd3;
  localparam logic [2:0] KIND_PRED   = 3'd4;
  localparam logic [2:0] KIND_SUCC   = 3'd5;
  localparam logic [2:0] KIND_CLEAR  = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADPOS  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  // One result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [7:0]         fpos;
    logic [7:0]         length;
  } sle_res_t;

endpackage

[src/sequential_list_engine_top.sv]
// Sequential list engine: list store, request sequencer and result port.
//
//   channel | ports                                             | direction
//   --------+---------------------------------------------------+----------
//   request | in_valid in_stall in_kind in_position in_item_value | in
//   result  | out_valid out_stall out_status out_result_value    | out
//           | out_found_position out_list_length                 |
//
// One request at a time. Get reads and captures its entry; insert shifts the tail up,
// then writes the new value (at once when appending); delete shifts the tail down;
// locate, predecessor and successor walk from the front. Errors, clear and empty
// searches go straight to the result. The walk is one entry per cycle of the list store.
// Reset clears the length; store contents need no clearing pass.
// in_stall is high while a request is in work; a stalled result holds the
// result register and the sequencer waits in its final state.
module sequential_list_engine_top #(
  parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_result_value,
  output logic [7:0]         out_found_position,
  output logic [7:0]         out_list_length
);
  import sle_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_PUT      = 10'b0000000010,
    S_UP       = 10'b0000000100,
    S_UPLAST   = 10'b0000001000,
    S_DOWN     = 10'b0000010000,
    S_DOWNLAST = 10'b0000100000,
    S_GET      = 10'b0001000000,
    S_CAPT     = 10'b0010000000,
    S_SCAN     = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         tgt_r, tgt_nxt;
  logic [AW-1:0]         pend_addr_r, pend_addr_nxt;
  logic                  pend_r, pend_nxt;
  logic                  pfirst_r, pfirst_nxt;
  logic                  scan_end_r, scan_end_nxt;
  logic [2:0]            kind_r, kind_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] prev_r, prev_nxt;
  sle_res_t              res_r, res_nxt;

  // List store, single write port and registered read
  logic [DATA_WIDTH-1:0] list_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  // Widened views for compares and conversions
  logic [XW-1:0]         pos_x, cnt_x, pm1_x, cm1_x, fpos_x;
  logic [AW-1:0]         last_idx;
  logic [63:0]           in_x, rd_x, prev_x;
  logic [DATA_WIDTH-1:0] in_val;

  // Result transaction
  logic     res_ready;
  sle_res_t res_load, res_out;

  assign pos_x    = XW'(in_position);
  assign cnt_x    = XW'(count_r);
  assign pm1_x    = pos_x - XW'(1);
  assign cm1_x    = cnt_x - XW'(1);
  assign last_idx = cm1_x[AW-1:0];
  assign fpos_x   = XW'(pend_addr_r) + XW'(1);
  assign in_x     = {32'b0, in_item_value};
  assign in_val   = in_x[DATA_WIDTH-1:0];
  assign rd_x     = 64'(rd_data_r);
  assign prev_x   = 64'(prev_r);

  assign in_stall = (state_r != S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    tgt_nxt       = tgt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pfirst_nxt    = 1'b0;
    scan_end_nxt  = scan_end_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    prev_nxt      = prev_r;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = tgt_r;
    wr_data       = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt        = in_val;
          kind_nxt       = in_kind;
          tgt_nxt        = pm1_x[AW-1:0];
          scan_end_nxt   = 1'b0;
          res_nxt.status = ST_OK;
          res_nxt.value  = '0;
          res_nxt.fpos   = '0;
          res_nxt.length = '0;
          state_nxt      = S_DONE;
          unique case (in_kind) inside
            KIND_INSERT: begin
              if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                res_nxt.status = ST_BADPOS;
              end else if (count_r == CW'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
              end else if (pm1_x == cnt_x) begin
                state_nxt = S_PUT;
              end else begin
                idx_nxt   = last_idx;
                state_nxt = S_UP;
              end
            end
            KIND_DELETE, KIND_GET: begin
              if (pos_x == '0 || pos_x > cnt_x) begin
                res_nxt.status = ST_BADPOS;
              end else begin
                idx_nxt   = pm1_x[AW-1:0];
                state_nxt = (in_kind == KIND_DELETE) ? S_DOWN : S_GET;
              end
            end
            KIND_LOCATE, KIND_PRED, KIND_SUCC: begin
              if (count_r == '0) begin
                res_nxt.status = ST_NOMATCH;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Write the new value into the opened slot
      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = tgt_r;
        wr_data   = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      // Shift tail up: read entry k, write it to k+1 in the next cycle
      S_UP: begin
        rd_en         = 1'b1;
        rd_addr       = idx_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = idx_r;
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r + AW'(1);
          wr_data = rd_data_r;
        end
        if (idx_r == tgt_r) begin
          state_nxt = S_UPLAST;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end

      S_UPLAST: begin
        wr_en     = 1'b1;
        wr_addr   = pend_addr_r + AW'(1);
        wr_data   = rd_data_r;
        state_nxt = S_PUT;
      end

      // Shift tail down; the first read is the removed entry
      S_DOWN, S_DOWNLAST: begin
        if (state_r == S_DOWN) begin
          rd_en         = 1'b1;
          rd_addr       = idx_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r;
          pfirst_nxt    = (idx_r == tgt_r);
          if (idx_r == last_idx) begin
            state_nxt = S_DOWNLAST;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
        if (pend_r) begin
          if (pfirst_r) begin
            res_nxt.value = rd_x[31:0];
          end else begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_r - AW'(1);
            wr_data = rd_data_r;
          end
        end
      end

      S_GET: begin
        rd_en     = 1'b1;
        rd_addr   = tgt_r;
        state_nxt = S_CAPT;
      end

      S_CAPT: begin
        res_nxt.value = rd_x[31:0];
        state_nxt     = S_DONE;
      end

      // Linear search, one read issued per cycle, compare in the cycle after each read
      S_SCAN: begin
        if (!scan_end_r) begin
          rd_en         = 1'b1;
          rd_addr       = idx_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r;
          if (idx_r == last_idx) begin
            scan_end_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
        if (pend_r) begin
          prev_nxt = rd_data_r;
          if (rd_data_r == val_r) begin
            state_nxt = S_DONE;
            case (kind_r)
              KIND_LOCATE: begin
                res_nxt.fpos = fpos_x[7:0];
              end
              KIND_PRED: begin
                if (pend_addr_r != '0) begin
                  res_nxt.value = prev_x[31:0];
                end else begin
                  res_nxt.status = ST_NOMATCH;
                end
              end
              default: begin
                // read of the next entry was issued this cycle
                if (pend_addr_r != last_idx) begin
                  state_nxt = S_CAPT;
                end else begin
                  res_nxt.status = ST_NOMATCH;
                end
              end
            endcase
          end else if (pend_addr_r == last_idx) begin
            res_nxt.status = ST_NOMATCH;
            state_nxt      = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      pend_r     <= 1'b0;
      pfirst_r   <= 1'b0;
      scan_end_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      pend_r     <= pend_nxt;
      pfirst_r   <= pfirst_nxt;
      scan_end_r <= scan_end_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    tgt_r       <= tgt_nxt;
    pend_addr_r <= pend_addr_nxt;
    kind_r      <= kind_nxt;
    val_r       <= val_nxt;
    prev_r      <= prev_nxt;
    res_r       <= res_nxt;
  end

  // List store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      list_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= list_mem[rd_addr];
    end
  end

  // Result transaction with the current length
  always_comb begin
    res_load        = res_r;
    res_load.length = cnt_x[7:0];
  end

  sle_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (state_r == S_DONE),
    .load_res   (res_load),
    .load_ready (res_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res_out)
  );

  assign out_status         = res_out.status;
  assign out_result_value   = res_out.value;
  assign out_found_position = res_out.fpos;
  assign out_list_length    = res_out.length;

endmodule

[src/sle_out_stage.sv]
// Output register stage holding one finished result transaction.
module sle_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_valid,
  input  sle_pkg::sle_res_t load_res,
  output logic             load_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output sle_pkg::sle_res_t out_res
);
  import sle_pkg::*;

  logic     valid_r;
  sle_res_t res_r;

  // Register is free when empty or being drained this cycle
  assign load_ready = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sequential list engine: directed and random requests.
module tb_top;
  import sle_pkg::*;

  localparam int          LIST_CAP    = sle_pkg::CAPACITY_DEF;
  localparam int          PHASE_ITEMS = 410;
  localparam int          SETTLE_CYC  = 300;
  localparam int          MAX_PRINTS  = 100;
  // kind code with no operation behind it
  localparam logic [2:0]  KIND_UNUSED = 3'd7;

  // Mirror of the list: predicts each result and holds the ones still owed
  class list_mirror;
    logic signed [31:0] store [sle_pkg::CAPACITY_DEF];
    int                 count;
    sle_res_t           pending [$];
    int                 errors;

    function new();
      count  = 0;
      errors = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    // index of the first entry equal to v, count when absent
    function int first_hit(logic signed [31:0] v);
      for (int k = 0; k < count; k++) begin
        if (store[k] == v) return k;
      end
      return count;
    endfunction

    // apply one accepted request and queue its expected result
    function void note_request(logic [2:0] kind, logic [7:0] pos, logic signed [31:0] val);
      sle_res_t want;
      int       m;
      want = '0;
      want.status = ST_OK;
      case (kind)
        KIND_INSERT: begin
          if (pos < 1 || pos > count + 1) begin
            want.status = ST_BADPOS;
          end else if (count >= sle_pkg::CAPACITY_DEF) begin
            want.status = ST_FULL;
          end else begin
            for (int k = count; k > pos - 1; k--) store[k] = store[k-1];
            store[pos-1] = val;
            count++;
          end
        end
        KIND_DELETE: begin
          if (pos < 1 || pos > count) begin
            want.status = ST_BADPOS;
          end else begin
            want.value = store[pos-1];
            for (int k = pos; k < count; k++) store[k-1] = store[k];
            count--;
          end
        end
        KIND_GET: begin
          if (pos < 1 || pos > count) want.status = ST_BADPOS;
          else want.value = store[pos-1];
        end
        KIND_LOCATE: begin
          m = first_hit(val);
          if (m < count) want.fpos = 8'(m + 1);
          else want.status = ST_NOMATCH;
        end
        KIND_PRED: begin
          m = first_hit(val);
          if (m < count && m > 0) want.value = store[m-1];
          else want.status = ST_NOMATCH;
        end
        KIND_SUCC: begin
          m = first_hit(val);
          if (m + 1 < count) want.value = store[m+1];
          else want.status = ST_NOMATCH;
        end
        KIND_CLEAR: begin
          count = 0;
        end
        default: begin
        end
      endcase
      want.length = 8'(count);
      pending.push_back(want);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // compare one result transaction with the oldest expectation
    task check_result(sle_res_t got);
      sle_res_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending, status", 32'(got.status), '0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      if (got.value !== want.value) report("result_value", got.value, want.value);
      if (got.fpos !== want.fpos) report("found_position", 32'(got.fpos), 32'(want.fpos));
      if (got.length !== want.length) report("list_length", 32'(got.length), 32'(want.length));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_kind;
  logic [7:0]         in_position;
  logic signed [31:0] in_item_value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic signed [31:0] out_result_value;
  logic [7:0]         out_found_position;
  logic [7:0]         out_list_length;

  int         send_pct;
  int         recv_pct;
  list_mirror mirror;

  sequential_list_engine_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_value   (out_result_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop for a hung block
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      mirror.check_result({out_status, out_result_value, out_found_position, out_list_length});
  end

  // drive one request, with random idle cycles ahead, until the block takes it
  task automatic send_request(input logic [2:0] kind, input logic [7:0] pos,
                              input logic signed [31:0] val);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_position   <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    mirror.note_request(kind, pos, val);
  endtask

  initial begin
    int                 r;
    int                 lim;
    int                 ins_w;
    int                 del_w;
    int                 dup_pct;
    int                 goal;
    int                 dwell;
    logic [2:0]         kind;
    logic [7:0]         pos;
    logic signed [31:0] val;

    mirror   = new();
    send_pct = 23;
    recv_pct = 50;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_GET;
    in_position   <= '0;
    in_item_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, bad positions, extremes, first-match and neighbor edges
    send_request(KIND_GET,    8'd1,   32'sd0);
    send_request(KIND_DELETE, 8'd1,   32'sd0);
    send_request(KIND_LOCATE, 8'd0,   32'sd0);
    send_request(KIND_PRED,   8'd0,   32'sd0);
    send_request(KIND_SUCC,   8'd0,   32'sd0);
    send_request(KIND_INSERT, 8'd0,   32'sd5);
    send_request(KIND_INSERT, 8'd2,   32'sd5);
    send_request(KIND_INSERT, 8'd1,   32'h7fffffff);
    send_request(KIND_INSERT, 8'd1,   32'h80000000);
    send_request(KIND_INSERT, 8'd3,   -32'sd1);
    send_request(KIND_INSERT, 8'd2,   32'sd0);
    send_request(KIND_INSERT, 8'd2,   -32'sd1);
    send_request(KIND_GET,    8'd5,   32'sd0);
    send_request(KIND_GET,    8'd6,   32'sd0);
    send_request(KIND_GET,    8'd255, 32'sd0);
    send_request(KIND_DELETE, 8'd0,   32'sd0);
    send_request(KIND_LOCATE, 8'd0,   -32'sd1);
    send_request(KIND_LOCATE, 8'd0,   32'sd12345);
    send_request(KIND_PRED,   8'd0,   32'h80000000);
    send_request(KIND_PRED,   8'd0,   -32'sd1);
    send_request(KIND_SUCC,   8'd0,   -32'sd1);
    send_request(KIND_DELETE, 8'd5,   32'sd0);
    send_request(KIND_SUCC,   8'd0,   32'h7fffffff);
    send_request(KIND_DELETE, 8'd1,   32'sd0);
    send_request(KIND_UNUSED, 8'hff,  32'hffffffff);
    send_request(KIND_CLEAR,  8'd0,   32'sd0);

    // random: length steered toward a moving goal, full list included
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_pct = 23; recv_pct = 50; end
        1: begin send_pct = 50; recv_pct = 23; end
        default: begin send_pct = 0; recv_pct = 0; end
      endcase
      goal  = LIST_CAP;
      dwell = $urandom_range(5, 40);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // retarget after dwelling at the goal
        if (mirror.count == goal) begin
          if (dwell == 0) begin
            r = $urandom_range(0, 99);
            if (r < 25) goal = LIST_CAP;
            else if (r < 40) goal = $urandom_range(0, 3);
            else goal = $urandom_range(0, LIST_CAP);
            dwell = $urandom_range(5, 40);
          end else begin
            dwell--;
          end
        end
        if (mirror.count < goal) begin
          ins_w = 65; del_w = 5;
        end else if (mirror.count == goal) begin
          ins_w = 25; del_w = 25;
        end else begin
          ins_w = 5; del_w = 65;
        end

        // request kind
        r = $urandom_range(0, 99);
        if (r < ins_w) kind = KIND_INSERT;
        else if (r < ins_w + del_w) kind = KIND_DELETE;
        else if (r < ins_w + del_w + 1) kind = KIND_CLEAR;
        else if (r < ins_w + del_w + 3) kind = KIND_UNUSED;
        else begin
          case (r % 4)
            0: kind = KIND_GET;
            1: kind = KIND_LOCATE;
            2: kind = KIND_PRED;
            default: kind = KIND_SUCC;
          endcase
        end

        // position: mostly in range, else zero, just past the end, or anything
        lim = (kind == KIND_INSERT) ? mirror.count + 1 : mirror.count;
        r = $urandom_range(0, 99);
        if (r < 75) pos = (lim == 0) ? 8'd1 : 8'($urandom_range(1, lim));
        else if (r < 83) pos = 8'd0;
        else if (r < 93) pos = 8'(lim + 1);
        else pos = 8'($urandom_range(0, 255));

        // value: a stored entry, a corner value or anything
        dup_pct = (kind == KIND_INSERT) ? 15 : 60;
        r = $urandom_range(0, 99);
        if (mirror.count > 0 && r < dup_pct) begin
          val = mirror.store[$urandom_range(0, mirror.count - 1)];
        end else if (r < dup_pct + 15) begin
          case ($urandom_range(0, 5))
            0: val = 32'sd0;
            1: val = -32'sd1;
            2: val = 32'h7fffffff;
            3: val = 32'h80000000;
            default: val = $urandom_range(0, 7);
          endcase
        end else begin
          val = $urandom;
        end

        send_request(kind, pos, val);
      end
    end

    // drain and watch for stray results
    in_valid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mirror.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[sequential_list_engine_top.f]
src/sle_pkg.sv
src/sle_out_stage.sv
src/sequential_list_engine_top.sv
tb/tb_top.sv
